/* rtl/cle_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the canonical line editor
// no dependencies

package cle_pkg;

  localparam int LINE_LENGTH_DEF = 64;

  localparam logic [7:0] BYTE_BACKSPACE = 8'h08;
  localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } cle_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input request may be taken
    logic append;    // store the byte and grow the line
    logic erase;     // drop the last stored byte
    logic flush;     // store the newline and start the drain
    logic drain_en;  // line is being read out
  } cle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic port_open;
    logic is_bs;
    logic is_nl;
    logic empty;
    logic full;
    logic drain_done;
  } cle_sts_t;

endpackage

/* rtl/canonical_line_editor.sv */
`timescale 1ns / 1ps
// top level of the canonical line editor: controller plus datapath
// depends on cle_pkg, cle_ctrl, cle_datapath
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_data: port_open
// in       in         in_tvalid / in_tready  in_tdata: in_byte
// out      out        out_tvalid / out_tready out_tdata: line_byte, out_tlast: last_of_line
//
// in_tready is high whenever no line is draining, and a typed byte is taken while it is high
// a newline on a non-empty line drains fill+1 bytes at one byte per cycle
// while out_tready is high, set by the single read port of the line store
// input resumes once the newline byte has reached the output register
// rst_n clears the fill count, port_open and the output valid; store contents stay
// a stalled out_tready holds the output register and pauses the store reads

module canonical_line_editor import cle_pkg::*; #(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,    // [0] port_open
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] line_byte
  output logic       out_tlast
);

  cle_cmd_t cmd;
  cle_sts_t sts;

  assign cfg_ready = 1'b1;
  assign in_tready = cmd.accept;

  cle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  cle_datapath #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

/* rtl/cle_ctrl.sv */
`timescale 1ns / 1ps
// controller: decodes each input request and sequences the line drain
// depends on cle_pkg

module cle_ctrl import cle_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  cle_sts_t sts,
  output cle_cmd_t cmd
);

  cle_state_t state_r, state_nxt;
  logic       take;

  assign take = (state_r == ST_IDLE) && in_tvalid && sts.port_open;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cmd.accept   = (state_r == ST_IDLE);
    cmd.drain_en = (state_r == ST_DRAIN);
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (sts.is_nl) begin
            if (!sts.empty) begin
              cmd.flush = 1'b1;
              state_nxt = ST_DRAIN;
            end
          end else if (!sts.full) begin
            if (sts.is_bs) begin
              cmd.erase = !sts.empty;
            end else begin
              cmd.append = 1'b1;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (sts.drain_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> state_r == ST_DRAIN)
    else $error("flush did not start a drain");

  assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.append, cmd.erase, cmd.flush}) <= 1)
    else $error("conflicting line commands");

  assert property (@(posedge clk) disable iff (!rst_n)
    sts.drain_done |-> state_r == ST_DRAIN)
    else $error("drain finished outside the drain state");

endmodule

/* rtl/cle_datapath.sv */
`timescale 1ns / 1ps
// datapath: line store, fill count, read pointer and output register
// depends on cle_pkg

module cle_datapath import cle_pkg::*; #(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_data,
  input  logic [7:0] in_tdata,
  input  logic       in_tvalid,
  input  logic       out_tready,
  output logic       out_tvalid,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  input  cle_cmd_t   cmd,
  output cle_sts_t   sts
);

  localparam int AW = $clog2(LINE_LENGTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(LINE_LENGTH - 1);

  logic [7:0]    mem [LINE_LENGTH];

  logic          port_open_r;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] end_r;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          issue_done_r, issue_done_nxt;
  logic          rd_valid_r, rd_valid_nxt;
  logic          rd_last_r;
  logic [7:0]    rd_data_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r;
  logic          out_last_r;
  logic          move, issue, wr_en;

  assign sts.port_open  = port_open_r;
  assign sts.is_bs      = (in_tdata == BYTE_BACKSPACE);
  assign sts.is_nl      = (in_tdata == BYTE_NEWLINE);
  assign sts.empty      = (fill_r == '0);
  assign sts.full       = (fill_r == LAST_IDX);
  assign sts.drain_done = move && rd_last_r;

  assign move  = rd_valid_r && (!out_valid_r || out_tready);
  assign issue = cmd.drain_en && !issue_done_r && (!rd_valid_r || move);
  assign wr_en = in_tvalid && (cmd.append || cmd.flush);

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.append) begin
      fill_nxt = fill_r + 1'b1;
    end else if (cmd.erase) begin
      fill_nxt = fill_r - 1'b1;
    end else if (cmd.flush) begin
      fill_nxt = '0;
    end
  end

  always_comb begin
    rd_ptr_nxt     = rd_ptr_r;
    issue_done_nxt = issue_done_r;
    if (cmd.flush) begin
      rd_ptr_nxt     = '0;
      issue_done_nxt = 1'b0;
    end else if (issue) begin
      rd_ptr_nxt     = rd_ptr_r + 1'b1;
      issue_done_nxt = (rd_ptr_r == end_r);
    end
  end

  assign rd_valid_nxt  = issue ? 1'b1 : (move ? 1'b0 : rd_valid_r);
  assign out_valid_nxt = move ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r] <= in_tdata;
    end
    if (issue) begin
      rd_data_r <= mem[rd_ptr_r];
      rd_last_r <= (rd_ptr_r == end_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      end_r <= fill_r;
    end
    if (move) begin
      out_data_r <= rd_data_r;
      out_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_open_r  <= 1'b0;
      fill_r       <= '0;
      rd_ptr_r     <= '0;
      issue_done_r <= 1'b1;
      rd_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        port_open_r <= cfg_data;
      end
      fill_r       <= fill_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      issue_done_r <= issue_done_nxt;
      rd_valid_r   <= rd_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> fill_r == '0)
    else $error("line not cleared after flush");

  assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r && out_valid_r && !out_tready |=> rd_valid_r)
    else $error("pending line byte lost during stall");

  assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> cmd.drain_en && !cmd.accept)
    else $error("store read outside the drain");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// testbench for canonical_line_editor: random and directed typed bytes with edits and newlines
// a line scoreboard predicts every emitted line; depends on cle_pkg and the rtl top level

module tb;
  import cle_pkg::*;

  localparam int LL          = LINE_LENGTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  class line_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
    } line_item_t;

    logic [7:0] line_buf [LL];
    int unsigned fill;
    bit port_open;
    int errors;
    line_item_t expected_line_q [$];

    function new();
      fill = 0;
      port_open = 1'b0;
      errors = 0;
    endfunction

    function void set_port(bit v);
      port_open = v;
    endfunction

    function int pending();
      return expected_line_q.size();
    endfunction

    function void note_typed_byte(logic [7:0] b);
      line_item_t it;
      if (!port_open) return;
      if (fill == LL - 1 && b != BYTE_NEWLINE) return;
      if (b == BYTE_BACKSPACE) begin
        if (fill > 0) fill--;
        return;
      end
      if (b == BYTE_NEWLINE) begin
        if (fill == 0) return;
        line_buf[fill] = b;
        for (int k = 0; k <= fill; k++) begin
          it.data = line_buf[k];
          it.last = (k == fill);
          expected_line_q.push_back(it);
        end
        fill = 0;
        return;
      end
      line_buf[fill] = b;
      fill++;
    endfunction

    function void check_line_byte(logic [7:0] data, logic last);
      line_item_t exp_it;
      if (expected_line_q.size() == 0) begin
        $display("%0t: unexpected line byte data=%02h last=%0b", $time, data, last);
        errors++;
        return;
      end
      exp_it = expected_line_q.pop_front();
      if (data !== exp_it.data) begin
        $display("%0t: line byte mismatch expected=%02h actual=%02h", $time, exp_it.data, data);
        errors++;
      end
      if (last !== exp_it.last) begin
        $display("%0t: last flag mismatch expected=%0b actual=%0b", $time, exp_it.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;      // [0] port_open
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;     // [7:0] in_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;            // [7:0] line_byte
  logic       out_tlast;

  line_scoreboard sb;
  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  int  typed_count = 0;
  bit  pressure_req = 1'b0;
  bit  pressure_taken = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  canonical_line_editor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // receiver: check results, random stalls, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_line_byte(out_tdata, out_tlast);
    if (pressure_req && !pressure_taken) begin
      pressure_taken <= 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // watchdog on cycles without any completed transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout", $time);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_port_open(input bit v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_port(v);
  endtask

  task automatic type_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_typed_byte(b);
    typed_count++;
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_NEWLINE || b == BYTE_BACKSPACE);
    return b;
  endfunction

  task automatic type_line(input int len);
    for (int i = 0; i < len; i++) begin
      type_byte(text_byte());
      if ($urandom_range(9) == 0) type_byte(BYTE_BACKSPACE);
    end
    type_byte(BYTE_NEWLINE);
  endtask

  // overflow the store, then a dropped backspace, then the flush
  task automatic type_full_line();
    repeat (LL - 1 + $urandom_range(1, 3)) type_byte(text_byte());
    type_byte(BYTE_BACKSPACE);
    type_byte(BYTE_NEWLINE);
  endtask

  task automatic random_traffic(input int n_items);
    int start;
    int pick;
    int len;
    start = typed_count;
    while (typed_count - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        type_line($urandom_range(1, 12));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) type_byte(8'($urandom_range(0, 255)));
      end else if (pick < 97) begin
        len = $urandom_range(0, 4);
        repeat (len) type_byte(text_byte());
        repeat (len + $urandom_range(1, 3)) type_byte(BYTE_BACKSPACE);
        if ($urandom_range(1)) type_byte(BYTE_NEWLINE);
      end else begin
        type_full_line();
      end
    end
  endtask

  task automatic set_mode(input int in_pct, input int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // port closed: everything ignored
    write_port_open(1'b0);
    type_byte(8'h41);
    type_byte(BYTE_NEWLINE);
    type_byte(BYTE_BACKSPACE);
    wait_quiet();

    write_port_open(1'b1);
    type_byte(BYTE_NEWLINE);
    type_byte(BYTE_BACKSPACE);
    type_byte(8'h00);
    type_byte(8'hFF);
    type_byte(8'h7F);
    type_byte(8'h80);
    type_byte(BYTE_BACKSPACE);
    type_byte(8'h51);
    type_byte(BYTE_NEWLINE);
    type_byte(8'h7A);
    type_byte(BYTE_NEWLINE);
    type_byte(8'h55);
    type_byte(8'hAA);
    type_byte(BYTE_BACKSPACE);
    type_byte(BYTE_BACKSPACE);
    type_byte(BYTE_BACKSPACE);
    type_byte(BYTE_NEWLINE);
    wait_quiet();

    // no idling
    set_mode(0, 0);
    type_full_line();
    random_traffic(25);

    // partial line survives a closed port
    type_byte(8'h31);
    type_byte(8'h32);
    wait_quiet();
    write_port_open(1'b0);
    set_mode(25, 25);
    repeat (18) type_byte(8'($urandom_range(0, 255)));
    wait_quiet();
    write_port_open(1'b1);
    type_byte(BYTE_NEWLINE);
    wait_quiet();

    set_mode(82, 0);
    random_traffic(25);
    wait_quiet();

    write_port_open(1'b1);
    set_mode(0, 82);
    random_traffic(25);
    wait_quiet();

    set_mode(25, 25);
    random_traffic(25);
    wait_quiet();

    // long receiver hold-off while bytes keep coming
    set_mode(0, 0);
    pressure_req <= 1'b1;
    type_line(6);
    type_line(10);
    repeat (8) type_byte(text_byte());
    type_byte(BYTE_NEWLINE);
    wait_quiet();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
